### hdl/aes_pkg.sv
// AES package: the S-box and inverse S-box tables, GF(2^8) helpers and shared constants.
// It has no dependencies. The aes_block_cipher top level imports it.
package aes_pkg;

    localparam int KeyW = 64;
    localparam int BlkW = 128;
    localparam int RkDepth = 60;
    localparam int RkAw = 6;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KLEN = 3'd4;
    localparam logic [2:0] REG_DEC  = 3'd5;

    typedef logic [7:0] t_byte;

    // Inverse S-box, entry 0 in the top byte.
    localparam logic [2047:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic t_byte sbox(input t_byte a);
        t_byte r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic t_byte xt(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gmul(input t_byte a, input t_byte b);
        t_byte p;
        t_byte x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        return p;
    endfunction

    // Byte b of the table sits at bit 8 * (255 - b).
    function automatic t_byte inv_sbox(input t_byte b);
        return INV_SBOX[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // SubBytes and ShiftRows on the 128-bit state, column c in bits [127-32c -: 32].
    function automatic logic [BlkW-1:0] enc_sub_shift(input logic [BlkW-1:0] s);
        logic [BlkW-1:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BlkW-1-8*(4*c+r) -: 8] = sbox(s[BlkW-1-8*(4*((c+r)%4)+r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [BlkW-1:0] dec_sub_shift(input logic [BlkW-1:0] s);
        logic [BlkW-1:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BlkW-1-8*(4*c+r) -: 8] =
                    inv_sbox(s[BlkW-1-8*(4*((c+4-r)%4)+r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [BlkW-1:0] mix(input logic [BlkW-1:0] s, input logic dec);
        logic [BlkW-1:0] t;
        t_byte m0, m1, m2, m3;
        t_byte col [4];
        t_byte o;
        m0 = dec ? 8'h0e : 8'h02;
        m1 = dec ? 8'h0b : 8'h03;
        m2 = dec ? 8'h0d : 8'h01;
        m3 = dec ? 8'h09 : 8'h01;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[BlkW-1-8*(4*c+k) -: 8];
            for (int r = 0; r < 4; r++) begin
                o = gmul(m0, col[r]) ^ gmul(m1, col[(r+1)%4])
                  ^ gmul(m2, col[(r+2)%4]) ^ gmul(m3, col[(r+3)%4]);
                t[BlkW-1-8*(4*c+r) -: 8] = o;
            end
        end
        return t;
    endfunction

endpackage

### hdl/aes_block_cipher.sv
// AES block cipher top level: key expansion into a round-key memory and an iterative round loop.
// It depends on aes_pkg for the S-box tables, the GF(2^8) helpers and the constants.
//
// Usage: write the key words, the key length and the mode through the i_cfg_* port while
// the block is idle. Blocks enter on the s_axis channel with block_high in tdata[63:0] and
// block_low in tdata[127:64]; results leave on m_axis packed the same way.
// For every block, the key schedule is first expanded into the round-key memory, one
// 32-bit word per cycle (44, 52 or 60 words). Each round then loads its four key words,
// one word per cycle through the registered read port, and then applies the round. A new
// block is taken only once the previous one has finished its rounds. The key expansion
// and the single read port set the time per block. An input item is taken only while the
// block is idle.
// The finished result sits in an output register, which holds it while m_axis_tready
// stays low. A next block may be taken and processed meanwhile; it waits after its last
// round until the output register is free, and the input stays stalled until then.
// Reset clears the control state, the output valid flag and the configuration registers.
// After reset the block is idle and ready. The round-key memory needs no clearing.
module aes_block_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [aes_pkg::KeyW-1:0]  i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from the lowest bit: block_high [63:0], block_low [127:64].
    input  logic [aes_pkg::BlkW-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // Fields from the lowest bit: result_high [63:0], result_low [127:64].
    output logic [aes_pkg::BlkW-1:0]  m_axis_tdata
);
    import aes_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEXP = 3'd1;
    localparam logic [2:0] ST_KLD  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [KeyW-1:0] r_key [4];
    logic [1:0]      r_klen;
    logic            r_dec;

    logic [31:0]     r_mem [RkDepth];
    logic [31:0]     r_rdata;

    logic [2:0]      r_state;
    logic [RkAw-1:0] r_widx;
    logic [31:0]     r_prev;
    logic [31:0]     r_back [8];   // Last Nk words, newest in entry 0.
    logic [7:0]      r_rcon;
    logic [2:0]      r_kpos;       // Word index modulo Nk.
    logic [3:0]      r_rnd;        // Round whose key is being loaded.
    logic [3:0]      r_cnt;        // Rounds done.
    logic [2:0]      r_kword;      // Key word read phase, 0..4.
    logic [BlkW-1:0] r_blk;
    logic [BlkW-1:0] r_rk;
    logic            r_mvalid;
    logic [BlkW-1:0] r_mdata;

    logic [3:0]      w_nk;
    logic [3:0]      w_nr;
    logic [RkAw-1:0] w_total;
    logic [31:0]     w_t;
    logic [31:0]     w_new;
    logic [RkAw-1:0] w_raddr;
    logic [BlkW-1:0] w_after;
    logic [BlkW-1:0] w_ss;
    logic            w_last;
    logic [RkAw-1:0] w_nxt;
    logic [31:0]     w_kw;

    always_comb begin
        case (r_klen)
            KLEN_128: begin w_nk = 4'd4; w_nr = 4'd10; end
            KLEN_192: begin w_nk = 4'd6; w_nr = 4'd12; end
            default:  begin w_nk = 4'd8; w_nr = 4'd14; end
        endcase
        w_total = RkAw'({w_nr, 2'b00} + 6'd4);
    end

    // Key schedule word from the previous word and the word Nk places back.
    always_comb begin
        w_t = r_prev;
        if (r_kpos == 3'd0) begin
            w_t = sub_word({r_prev[23:0], r_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (w_nk == 4'd8 && r_kpos == 3'd4) begin
            w_t = sub_word(r_prev);
        end
        w_new = w_t ^ r_back[w_nk[2:0] - 3'd1];
    end

    // Key word number r_widx + 1 taken straight from the key registers.
    assign w_nxt = r_widx + 1'b1;
    assign w_kw  = r_widx[0] ? r_key[w_nxt[2:1]][63:32] : r_key[w_nxt[2:1]][31:0];

    // The address of the round-key word to read during key loading.
    assign w_raddr = RkAw'({r_rnd, 2'b00} + {4'd0, r_kword[1:0]});

    assign w_last = r_dec ? (r_cnt == w_nr) : (r_cnt == w_nr);
    always_comb begin
        w_ss = r_dec ? dec_sub_shift(r_blk) : enc_sub_shift(r_blk);
        if (r_cnt == 4'd0) begin
            w_after = r_blk ^ r_rk;
        end else if (r_dec) begin
            w_after = (r_cnt == w_nr) ? (w_ss ^ r_rk) : mix(w_ss ^ r_rk, 1'b1);
        end else begin
            w_after = (r_cnt == w_nr) ? (w_ss ^ r_rk) : (mix(w_ss, 1'b0) ^ r_rk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_KEXP) begin
            r_mem[r_widx] <= (r_widx < RkAw'(w_nk))
                           ? r_back[0] : w_new;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
            r_klen   <= 2'd0;
            r_dec    <= 1'b0;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY0: r_key[0] <= i_cfg_data;
                    REG_KEY1: r_key[1] <= i_cfg_data;
                    REG_KEY2: r_key[2] <= i_cfg_data;
                    REG_KEY3: r_key[3] <= i_cfg_data;
                    REG_KLEN: r_klen   <= i_cfg_data[1:0];
                    REG_DEC:  r_dec    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_mvalid && m_axis_tready) r_mvalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_blk   <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        r_widx  <= '0;
                        r_kpos  <= 3'd0;
                        r_rcon  <= 8'h01;
                        r_back[0] <= r_key[0][63:32];
                        r_state <= ST_KEXP;
                    end
                end
                ST_KEXP: begin
                    // Words 0..Nk-1 come from the key registers, shifted in one per cycle.
                    if (w_nxt < RkAw'(w_nk)) begin
                        for (int i = 1; i < 8; i++) r_back[i] <= r_back[i-1];
                        r_back[0] <= w_kw;
                        r_prev    <= w_kw;
                        r_kpos    <= 3'd0;
                    end else if (r_widx < RkAw'(w_nk)) begin
                        // The last key word is already at the head of the window.
                        r_prev    <= r_back[0];
                        r_kpos    <= 3'd0;
                    end else begin
                        for (int i = 1; i < 8; i++) r_back[i] <= r_back[i-1];
                        r_back[0] <= w_new;
                        r_prev    <= w_new;
                        if (r_kpos == 3'd0) r_rcon <= xt(r_rcon);
                        r_kpos <= (r_kpos + 3'd1 == w_nk[2:0]) ? 3'd0 : r_kpos + 3'd1;
                    end
                    if (w_nxt == w_total) begin
                        r_cnt   <= 4'd0;
                        r_rnd   <= r_dec ? w_nr : 4'd0;
                        r_kword <= 3'd0;
                        r_state <= ST_KLD;
                    end
                    r_widx <= w_nxt;
                end
                ST_KLD: begin
                    if (r_kword != 3'd0) r_rk <= {r_rk[BlkW-33:0], r_rdata};
                    if (r_kword == 3'd4) r_state <= ST_RND;
                    r_kword <= r_kword + 3'd1;
                end
                ST_RND: begin
                    r_blk   <= w_after;
                    r_kword <= 3'd0;
                    r_cnt   <= r_cnt + 4'd1;
                    r_rnd   <= r_dec ? r_rnd - 4'd1 : r_rnd + 4'd1;
                    r_state <= w_last ? ST_OUT : ST_KLD;
                end
                ST_OUT: begin
                    if (!r_mvalid) begin
                        r_mdata  <= r_blk;
                        r_mvalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {r_mdata[63:0], r_mdata[127:64]};

endmodule
